// ===== design/utcx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utcx_pkg
// Shared types, codes and small tables for the UTC expiry checker.
// ----------------------------------------------------------------------------
package utcx_pkg;

  // expiry kind codes
  localparam logic [1:0] KIND_ABSENT    = 2'd0;
  localparam logic [1:0] KIND_NONSTRING = 2'd1;
  localparam logic [1:0] KIND_STRING    = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
  localparam logic [1:0] VERDICT_INVALID = 2'd1;
  localparam logic [1:0] VERDICT_EXPIRED = 2'd2;

  // register map
  localparam int          PADDR_W        = 4;
  localparam logic        REG_FLOOR      = 1'b0;
  localparam logic [39:0] FLOOR_RESET    = 40'd1704067200;

  // pipeline depth from accepted start to done
  localparam int          LATENCY        = 5;

  typedef struct packed {
    logic [1:0]  expiry_kind;
    logic        text_format_ok;
    logic [13:0] year_value;
    logic [6:0]  month_value;
    logic [6:0]  day_value;
    logic [6:0]  hour_value;
    logic [6:0]  minute_value;
    logic [6:0]  second_value;
    logic [39:0] now_seconds;
  } utcx_in_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [37:0] expiry_seconds;
    logic        clock_trusted;
  } utcx_out_t;

  // days in month 1..12, February as 28
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:    r = 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // days before month of a March-based year: (153*mp + 2) / 5
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/utc_expiry_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_expiry_check
// Expiry timestamp check: calendar validation, Unix-seconds conversion and
// comparison against the current time, with an APB trusted-floor register.
// ----------------------------------------------------------------------------
// Usage: drive an item and pulse start; busy is tied low, so a new item may
// enter on every clock. The verdict comes out on result with a one-cycle
// done strobe after five register stages (field checks and reciprocal
// divides, leap/day limit and era split, day-of-era sum, the days*86400
// multiply, and the final compare). There is no output backpressure: the
// receiver must take every beat the cycle it shows, and results leave in
// the order items went in. The trusted floor is 40 bits at byte address 0
// (64-bit data); write it only while no beat is in flight. Absent expiry
// accepts, a non-string or unknown kind is invalid, an untrusted clock
// accepts any string expiry unchecked, and an expiry at or before now is
// expired.
// ----------------------------------------------------------------------------
module utc_expiry_check (
  input  logic                           clk,
  input  logic                           rst,
  // command side
  input  logic                           start,
  output logic                           busy,
  input  utcx_pkg::utcx_in_t             item,
  output logic                           done,
  output utcx_pkg::utcx_out_t            result,
  // APB register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [utcx_pkg::PADDR_W-1:0]   paddr,
  input  logic [63:0]                    pwdata,
  output logic [63:0]                    prdata,
  output logic                           pready
);

  logic [39:0] floor;
  logic        wr_en;

  // fully pipelined, never stalls
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // register index is paddr[3]; low bits address bytes in the 64-bit word
  assign wr_en = psel && penable && pwrite && pready &&
                 (paddr[3] == utcx_pkg::REG_FLOOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      floor <= utcx_pkg::FLOOR_RESET;
    end else if (wr_en) begin
      floor <= pwdata[39:0];
    end
  end

  always_comb begin
    if (paddr[3] == utcx_pkg::REG_FLOOR) begin
      prdata = {24'd0, floor};
    end else begin
      prdata = '0;
    end
  end

  // the whole datapath; the user must keep floor stable while items are in flight; the block does not enforce this
  utcx_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .item     (item),
    .floor    (floor),
    .out_valid(done),
    .result   (result)
  );

endmodule

// ===== design/utcx_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utcx_pipe
// Five-stage validate / days-from-civil / compare pipeline, one beat a cycle.
// ----------------------------------------------------------------------------
module utcx_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  utcx_pkg::utcx_in_t  item,
  input  logic [39:0]         floor,
  output logic                out_valid,
  output utcx_pkg::utcx_out_t result
);

  // ---------------- stage 1: decode, range checks, reciprocal divides
  logic        c1_trusted;
  logic        c1_fields_ok;
  logic        c1_compute;
  logic [1:0]  c1_early;
  logic [13:0] c1_yy;
  logic [26:0] c1_q100_prod;
  logic [26:0] c1_era_prod;
  logic [3:0]  c1_mp;

  logic        s1_valid;
  logic        s1_compute;
  logic [1:0]  s1_early;
  logic        s1_trusted;
  logic [39:0] s1_now;
  logic [13:0] s1_y;
  logic [7:0]  s1_q100;
  logic [13:0] s1_yy;
  logic [5:0]  s1_era;
  logic [3:0]  s1_mp;
  logic [4:0]  s1_mlen;
  logic        s1_feb;
  logic [6:0]  s1_d;
  logic [6:0]  s1_h;
  logic [6:0]  s1_mi;
  logic [6:0]  s1_s;

  always_comb begin
    c1_trusted   = (item.now_seconds >= floor);
    c1_fields_ok = item.text_format_ok &&
                   (item.year_value >= 14'd1970) && (item.year_value <= 14'd9999) &&
                   (item.month_value >= 7'd1) && (item.month_value <= 7'd12) &&
                   (item.day_value >= 7'd1) && (item.hour_value <= 7'd23) &&
                   (item.minute_value <= 7'd59) && (item.second_value <= 7'd60);
    c1_compute   = (item.expiry_kind == utcx_pkg::KIND_STRING) && c1_trusted &&
                   c1_fields_ok;
    if (item.expiry_kind == utcx_pkg::KIND_ABSENT) begin
      c1_early = utcx_pkg::VERDICT_ACCEPT;
    end else if (item.expiry_kind != utcx_pkg::KIND_STRING) begin
      c1_early = utcx_pkg::VERDICT_INVALID;
    end else if (!c1_trusted) begin
      c1_early = utcx_pkg::VERDICT_ACCEPT;
    end else begin
      c1_early = utcx_pkg::VERDICT_INVALID;
    end
    // Jan/Feb belong to the previous March-based year
    c1_yy = (item.month_value <= 7'd2) ? item.year_value - 14'd1 : item.year_value;
    c1_mp = (item.month_value > 7'd2) ? item.month_value[3:0] - 4'd3
                                      : item.month_value[3:0] + 4'd9;
    // y/100 = (y*5243)>>19, yy/400 = (yy*5243)>>21, exact over 14 bits
    c1_q100_prod = {13'd0, item.year_value} * 27'd5243;
    c1_era_prod  = {13'd0, c1_yy} * 27'd5243;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_compute <= c1_compute;
    s1_early   <= c1_early;
    s1_trusted <= c1_trusted;
    s1_now     <= item.now_seconds;
    s1_y       <= item.year_value;
    s1_q100    <= c1_q100_prod[26:19];
    s1_yy      <= c1_yy;
    s1_era     <= c1_era_prod[26:21];
    s1_mp      <= c1_mp;
    s1_mlen    <= utcx_pkg::month_days(item.month_value[3:0]);
    s1_feb     <= (item.month_value == 7'd2);
    s1_d       <= item.day_value;
    s1_h       <= item.hour_value;
    s1_mi      <= item.minute_value;
    s1_s       <= item.second_value;
  end

  // ---------------- stage 2: leap year, day limit, year of era, time of day
  logic [13:0] c2_r100;
  logic        c2_leap;
  logic [4:0]  c2_lim;
  logic [13:0] c2_yoe;
  logic [16:0] c2_tod;

  logic        s2_valid;
  logic        s2_compute;
  logic [1:0]  s2_early;
  logic        s2_trusted;
  logic [39:0] s2_now;
  logic [8:0]  s2_yoe;
  logic [8:0]  s2_doy;
  logic [16:0] s2_tod;
  logic [23:0] s2_era_base;

  always_comb begin
    c2_r100 = s1_y - 14'({6'd0, s1_q100} * 14'd100);
    // div by 400 <=> div by 100 with quotient div by 4
    c2_leap = (s1_y[1:0] == 2'd0) && ((c2_r100 != 14'd0) || (s1_q100[1:0] == 2'd0));
    c2_lim  = (s1_feb && c2_leap) ? 5'd29 : s1_mlen;
    c2_yoe  = s1_yy - 14'({8'd0, s1_era} * 14'd400);
    c2_tod  = 17'({10'd0, s1_h} * 17'd3600) + 17'({10'd0, s1_mi} * 17'd60) +
              {10'd0, s1_s};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_compute  <= s1_compute && (s1_d <= {2'd0, c2_lim});
    s2_early    <= s1_early;
    s2_trusted  <= s1_trusted;
    s2_now      <= s1_now;
    s2_yoe      <= c2_yoe[8:0];
    s2_doy      <= utcx_pkg::month_offset(s1_mp) + {2'd0, s1_d} - 9'd1;
    s2_tod      <= c2_tod;
    s2_era_base <= {18'd0, s1_era} * 24'd146097;
  end

  // ---------------- stage 3: day of era, days since epoch
  logic [14:0] c3_q_prod;
  logic [17:0] c3_doe;
  logic [23:0] c3_days;

  logic        s3_valid;
  logic        s3_compute;
  logic [1:0]  s3_early;
  logic        s3_trusted;
  logic [39:0] s3_now;
  logic [21:0] s3_days;
  logic [16:0] s3_tod;

  always_comb begin
    // yoe/100 = (yoe*41)>>12 for yoe < 400
    c3_q_prod = {6'd0, s2_yoe} * 15'd41;
    c3_doe    = 18'({9'd0, s2_yoe} * 18'd365) + {11'd0, s2_yoe[8:2]} -
                {15'd0, c3_q_prod[14:12]} + {9'd0, s2_doy};
    c3_days   = s2_era_base + {6'd0, c3_doe} - 24'd719468;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_compute <= s2_compute;
    s3_early   <= s2_early;
    s3_trusted <= s2_trusted;
    s3_now     <= s2_now;
    s3_days    <= c3_days[21:0];
    s3_tod     <= s2_tod;
  end

  // ---------------- stage 4: seconds
  logic [38:0] c4_prod;

  logic        s4_valid;
  logic        s4_compute;
  logic [1:0]  s4_early;
  logic        s4_trusted;
  logic [39:0] s4_now;
  logic [37:0] s4_secs;

  assign c4_prod = {17'd0, s3_days} * 39'd86400;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_compute <= s3_compute;
    s4_early   <= s3_early;
    s4_trusted <= s3_trusted;
    s4_now     <= s3_now;
    s4_secs    <= c4_prod[37:0] + {21'd0, s3_tod};
  end

  // ---------------- stage 5: compare against now, result register
  utcx_pkg::utcx_out_t c5_res;

  always_comb begin
    c5_res.clock_trusted = s4_trusted;
    if (s4_compute) begin
      c5_res.expiry_seconds = s4_secs;
      c5_res.verdict = ({2'd0, s4_secs} <= s4_now) ? utcx_pkg::VERDICT_EXPIRED
                                                   : utcx_pkg::VERDICT_ACCEPT;
    end else begin
      c5_res.expiry_seconds = '0;
      c5_res.verdict        = s4_early;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s4_valid;
    end
    result <= c5_res;
  end

endmodule

// ===== design/utcx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utcx_checker
// Port-level checks for the expiry checker, bound to the top level.
// ----------------------------------------------------------------------------
module utcx_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic                done,
  input  utcx_pkg::utcx_out_t result
);

  // every accepted beat comes out after the fixed latency
  a_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted beat produced no result");

  // no result without a beat accepted the matching cycle earlier
  a_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 5))
    else $error("result without accepted beat");

  // untrusted clock or invalid verdict never reports a time
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (!result.clock_trusted || result.verdict == utcx_pkg::VERDICT_INVALID))
      |-> (result.expiry_seconds == '0))
    else $error("expiry seconds reported where none computed");

  // an expired verdict needs a trusted clock
  a_exp: assert property (@(posedge clk) disable iff (rst)
    (done && result.verdict == utcx_pkg::VERDICT_EXPIRED) |-> result.clock_trusted)
    else $error("expired verdict with untrusted clock");

endmodule

bind utc_expiry_check utcx_checker u_utcx_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for utc_expiry_check. A queue of commands feeds a
// negedge driver. A posedge monitor predicts each accepted beat's verdict
// from its own calendar math and checks it against the done strobe. The
// trusted floor is rewritten over APB between phases, each phase with its
// own sender gap rate.
// ----------------------------------------------------------------------------
module tb_top;
  import utcx_pkg::*;

  // kind code 3 is unused by the block but still has to be exercised
  localparam logic [1:0]         KIND_RESERVED = 2'd3;
  localparam logic [PADDR_W-1:0] FLOOR_ADDR    = PADDR_W'(8 * REG_FLOOR);
  localparam logic [39:0]        NOW_MAX       = 40'hFF_FFFF_FFFF;
  // cycles without an accepted beat or a result before the run is called hung
  localparam int                 STALL_LIMIT   = 3000;
  localparam int                 MAX_PRINTS    = 40;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  utcx_in_t           item;
  logic               done;
  utcx_out_t          result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;

  utcx_in_t  cmd_queue[$];        // commands not yet driven
  utcx_out_t verdict_queue[$];    // predicted results, oldest first
  logic [39:0] floor_copy;        // bench's view of the trusted floor
  int        gap_pct;             // sender idle chance per cycle, percent
  int        sent_cnt;            // beats put on the bus by the driver
  int        taken_cnt;           // beats the block accepted
  int        mismatches;
  int        stall_cycles;

  utc_expiry_check u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Calendar math
  // --------------------------------------------------------------------------
  function automatic bit leap_year(int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int days_in_month(int y, int m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Unix seconds of a checked date; years are shifted to start in March so
  // the leap day falls at the end of the shifted year.
  function automatic longint epoch_seconds(int y, int m, int d, int h, int mi, int s);
    longint yr, era, yoe, mar_month, doy, doe, days;
    yr        = (m <= 2) ? y - 1 : y;
    era       = yr / 400;
    yoe       = yr - era * 400;
    mar_month = (m > 2) ? m - 3 : m + 9;
    doy       = (153 * mar_month + 2) / 5 + d - 1;
    doe       = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days      = era * 146097 + doe - 719468;
    return days * 86400 + h * 3600 + mi * 60 + s;
  endfunction

  // Expected result of one command under a given floor.
  function automatic utcx_out_t judge_expiry(utcx_in_t c, logic [39:0] floor_val);
    utcx_out_t r;
    int     y, m, d, h, mi, s;
    longint secs;
    y  = c.year_value;
    m  = c.month_value;
    d  = c.day_value;
    h  = c.hour_value;
    mi = c.minute_value;
    s  = c.second_value;
    r.verdict        = VERDICT_ACCEPT;
    r.expiry_seconds = '0;
    r.clock_trusted  = (c.now_seconds >= floor_val);
    if (c.expiry_kind == KIND_STRING) begin
      // untrusted clock: accepted without looking at the text at all
      if (r.clock_trusted) begin
        if (!c.text_format_ok || y < 1970 || y > 9999 || m < 1 || m > 12 || d < 1 ||
            d > days_in_month(y, m) || h > 23 || mi > 59 || s > 60) begin
          r.verdict = VERDICT_INVALID;
        end else begin
          secs             = epoch_seconds(y, m, d, h, mi, s);
          r.expiry_seconds = secs[37:0];
          // an expiry equal to now already counts as expired
          r.verdict = (secs <= longint'(c.now_seconds)) ? VERDICT_EXPIRED : VERDICT_ACCEPT;
        end
      end
    end else if (c.expiry_kind != KIND_ABSENT) begin
      r.verdict = VERDICT_INVALID;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic utcx_in_t build_cmd(logic [1:0] kind, bit fmt, int y, int m, int d,
                                         int h, int mi, int s, logic [39:0] now);
    utcx_in_t c;
    c.expiry_kind    = kind;
    c.text_format_ok = fmt;
    c.year_value     = 14'(y);
    c.month_value    = 7'(m);
    c.day_value      = 7'(d);
    c.hour_value     = 7'(h);
    c.minute_value   = 7'(mi);
    c.second_value   = 7'(s);
    c.now_seconds    = now;
    return c;
  endfunction

  // Mostly well-formed stamps with now placed around the expiry, plus one
  // broken field, bad format, odd kinds and raw noise.
  function automatic utcx_in_t random_cmd();
    utcx_in_t    c;
    int unsigned pick;
    int          y, m, d, h, mi, s;
    longint      stamp, now;
    pick  = $urandom_range(99);
    y     = ($urandom_range(3) == 0) ? $urandom_range(9999, 1970) : $urandom_range(2100, 1970);
    m     = $urandom_range(12, 1);
    d     = $urandom_range(days_in_month(y, m), 1);
    h     = $urandom_range(23);
    mi    = $urandom_range(59);
    s     = $urandom_range(60);
    stamp = epoch_seconds(y, m, d, h, mi, s);
    case ($urandom_range(3))
      0:       now = stamp + longint'($urandom_range(6)) - 3;
      1:       now = stamp + longint'($urandom_range(2000000)) - 1000000;
      2:       now = longint'({$urandom_range(255), $urandom()});
      default: now = stamp + longint'($urandom()) - longint'(32'h8000_0000);
    endcase
    if (now < 0) now = 0;
    else if (now > longint'(NOW_MAX)) now = longint'(NOW_MAX);
    c = build_cmd(KIND_STRING, 1'b1, y, m, d, h, mi, s, now[39:0]);
    if (pick >= 60 && pick < 72) begin
      case ($urandom_range(5))
        0: c.year_value = $urandom_range(1) ? 14'($urandom_range(1969))
                                            : 14'($urandom_range(16383, 10000));
        1: c.month_value = $urandom_range(1) ? 7'd0 : 7'($urandom_range(127, 13));
        2: c.day_value = $urandom_range(1) ? 7'd0
                                           : 7'($urandom_range(127, days_in_month(y, m) + 1));
        3: c.hour_value = 7'($urandom_range(127, 24));
        4: c.minute_value = 7'($urandom_range(127, 60));
        default: c.second_value = 7'($urandom_range(127, 61));
      endcase
    end else if (pick >= 72 && pick < 80) begin
      c.text_format_ok = 1'b0;
    end else if (pick >= 80 && pick < 90) begin
      c.expiry_kind = 2'($urandom_range(3));
    end else if (pick >= 90) begin
      c.expiry_kind    = 2'($urandom_range(3));
      c.text_format_ok = 1'($urandom_range(1));
      c.year_value     = 14'($urandom_range(16383));
      c.month_value    = 7'($urandom_range(127));
      c.day_value      = 7'($urandom_range(127));
      c.hour_value     = 7'($urandom_range(127));
      c.minute_value   = 7'($urandom_range(127));
      c.second_value   = 7'($urandom_range(127));
      c.now_seconds    = 40'({$urandom_range(255), $urandom()});
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one command beat held until the block takes it
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && taken_cnt != sent_cnt)) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
        item  <= cmd_queue.pop_front();
        start <= 1'b1;
        sent_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on accept, check on done, watchdog on no progress
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    if (mismatches < MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    utcx_out_t want;
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (done) begin
        if (verdict_queue.size() == 0) begin
          flag_mismatch("result beat with no command pending");
        end else begin
          want = verdict_queue.pop_front();
          if (result.verdict !== want.verdict)
            flag_mismatch($sformatf("verdict %0d, want %0d", result.verdict, want.verdict));
          if (result.expiry_seconds !== want.expiry_seconds)
            flag_mismatch($sformatf("expiry_seconds %0d, want %0d",
                                    result.expiry_seconds, want.expiry_seconds));
          if (result.clock_trusted !== want.clock_trusted)
            flag_mismatch($sformatf("clock_trusted %0b, want %0b",
                                    result.clock_trusted, want.clock_trusted));
        end
      end
      if (start && !busy) begin
        verdict_queue.push_back(judge_expiry(item, floor_copy));
        taken_cnt++;
      end
      if (done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat accepted in %0d cycles", STALL_LIMIT);
        $display("utc_expiry_check: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // APB access and phase control
  // --------------------------------------------------------------------------
  task automatic floor_write(logic [39:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= FLOOR_ADDR;
    pwdata  <= {24'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    floor_copy = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic floor_readback();
    logic [63:0] got;
    @(negedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    paddr  <= FLOOR_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    if (got[39:0] !== floor_copy)
      flag_mismatch($sformatf("floor readback %0d, want %0d", got[39:0], floor_copy));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sender holds off until every driven command has produced its result.
  // Each command yields exactly one result, so nothing is in flight then.
  task automatic drain();
    while (cmd_queue.size() != 0 || sent_cnt != taken_cnt || verdict_queue.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    logic [39:0] phase_floor[5];
    int          phase_gap[5];
    int          phase_len[5];
    longint      mark;

    rst          = 1'b1;
    start        = 1'b0;
    item         = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    floor_copy   = FLOOR_RESET;
    gap_pct      = 0;
    sent_cnt     = 0;
    taken_cnt    = 0;
    mismatches   = 0;
    stall_cycles = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    floor_readback();

    // directed corners under the reset floor
    cmd_queue.push_back(build_cmd(KIND_ABSENT, 1'b0, 0, 0, 0, 99, 99, 99, 40'd0));
    cmd_queue.push_back(build_cmd(KIND_NONSTRING, 1'b1, 2030, 1, 1, 0, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_RESERVED, 1'b1, 2030, 1, 1, 0, 0, 0, NOW_MAX));
    // untrusted clock lets garbage through unchecked
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b0, 0, 0, 0, 99, 99, 99, FLOOR_RESET - 1));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b0, 2030, 1, 1, 0, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 1969, 12, 31, 23, 59, 59, NOW_MAX));
    // epoch start: expiry zero, expired against the floor itself
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 1970, 1, 1, 0, 0, 0, FLOOR_RESET));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 9999, 12, 31, 23, 59, 60, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 16383, 1, 1, 0, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 0, 1, 0, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 13, 1, 0, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 127, 127, 127, 127, 127, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 5, 0, 0, 0, 0, NOW_MAX));
    // February in leap and non-leap years, century rules included
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2024, 2, 29, 12, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2023, 2, 29, 12, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2000, 2, 29, 12, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2100, 2, 29, 12, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 4, 31, 0, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 12, 31, 0, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 6, 1, 24, 0, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 6, 1, 0, 60, 0, NOW_MAX));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 6, 1, 0, 0, 61, NOW_MAX));
    // expiry exactly at now, then one second later
    mark = epoch_seconds(2030, 6, 15, 12, 30, 45);
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 6, 15, 12, 30, 45, mark[39:0]));
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2030, 6, 15, 12, 30, 46, mark[39:0]));
    // leap second still one second ahead of now
    mark = epoch_seconds(2025, 6, 30, 23, 59, 60) - 1;
    cmd_queue.push_back(build_cmd(KIND_STRING, 1'b1, 2025, 6, 30, 23, 59, 60, mark[39:0]));
    repeat (300) cmd_queue.push_back(random_cmd());
    drain();

    phase_floor[0] = 40'd0;
    phase_floor[1] = NOW_MAX;
    phase_floor[2] = 40'({$urandom_range(1), $urandom()});
    phase_floor[3] = FLOOR_RESET;
    phase_floor[4] = 40'd1;
    phase_gap[0]   = 48;
    phase_gap[1]   = 20;
    phase_gap[2]   = 48;
    phase_gap[3]   = 20;
    phase_gap[4]   = 0;
    phase_len[0]   = 300;
    phase_len[1]   = 150;
    phase_len[2]   = 300;
    phase_len[3]   = 400;
    phase_len[4]   = 300;

    for (int p = 0; p < 5; p++) begin
      floor_write(phase_floor[p]);
      floor_readback();
      gap_pct = phase_gap[p];
      repeat (phase_len[p]) cmd_queue.push_back(random_cmd());
      drain();
    end

    // let any stray done show up before closing
    repeat (LATENCY + 4) @(negedge clk);
    if (mismatches == 0) begin
      $display("utc_expiry_check: match");
    end else begin
      $display("utc_expiry_check: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/utcx_pkg.sv
design/utcx_pipe.sv
design/utc_expiry_check.sv
design/utcx_checker.sv
bench/tb_top.sv
